// ===== rtl/sem_pkg.sv =====
// Shared types, constants and helpers for the Sobel edge magnitude block.
package sem_pkg;

    localparam int unsigned PIX_W     = 8;
    localparam int unsigned MAX_WIDTH = 256;
    localparam int unsigned ADDR_W    = $clog2(MAX_WIDTH);
    localparam int unsigned DIM_W     = 9;
    localparam int unsigned IDX_W     = 2;
    localparam int unsigned POS_W     = 8;

    localparam logic [IDX_W-1:0] CFG_IDX_WIDTH  = 2'd0;
    localparam logic [IDX_W-1:0] CFG_IDX_HEIGHT = 2'd1;

    localparam logic [DIM_W-1:0] WIDTH_RESET  = 9'd188;
    localparam logic [DIM_W-1:0] HEIGHT_RESET = 9'd120;
    localparam logic [DIM_W-1:0] DIM_MIN      = 9'd3;
    localparam logic [DIM_W-1:0] DIM_MAX      = 9'd256;

    // One column of the 3x3 window, oldest row on top.
    typedef struct packed {
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] mid;
        logic [PIX_W-1:0] bot;
    } column_t;

    // Line store entry: two rows above the current pixel.
    typedef struct packed {
        logic [PIX_W-1:0] middle;
        logic [PIX_W-1:0] upper;
    } line_entry_t;

    // Clamp a dimension register to 3..256 and return its last index.
    function automatic logic [POS_W-1:0] last_index(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] c;
        begin
            if (v < DIM_MIN) begin
                c = DIM_MIN;
            end else if (v > DIM_MAX) begin
                c = DIM_MAX;
            end else begin
                c = v;
            end
            last_index = POS_W'(c - 9'd1);
        end
    endfunction

endpackage

// ===== rtl/sobel_edge_magnitude_3x3_top.sv =====
// Top level of the streaming 3x3 Sobel edge magnitude block.
//
// Usage:
//   Pixels enter on the s_ channel in raster order, one per beat; s_tdata holds
//   the grey value and s_tuser flags the first pixel of a frame (it forces the
//   column and row counters to zero before the pixel is placed).
//   Results leave on the m_ channel, one beat per interior pixel only; border
//   pixels produce nothing. m_tdata = {out_y, out_x, edge_magnitude} and
//   m_tlast marks the last interior pixel of the frame.
//   Frame size comes from the cfg write port (index 0 width, 1 height),
//   clamped to 3..256; write it only while the block is idle.
// Timing:
//   One pixel per cycle sustained while the output keeps up (see Stall).
//   A result passes the stage 1 registers, which take the line store read,
//   then the window/arithmetic stage into the output register. The RAM is
//   read for each accepted pixel and written back when it leaves stage 1;
//   a read hitting the entry written in the same cycle uses a forward register.
// Reset (aresetn low, synchronous): counters, window and pipeline valid bits
//   clear, width/height return to 188/120. Line store contents stay unknown.
// Stall: while m_tready is low with a result held, the kernel stage holds
//   and s_tready drops; pixels that produce no result still pass through.
module sobel_edge_magnitude_3x3_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    // input pixel stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // [7:0] pixel
    input  logic                          s_tuser,   // [0] frame_start
    // result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [23:0]                   m_tdata,   // [7:0] edge_magnitude,
                                                     // [15:8] out_x, [23:16] out_y
    output logic                          m_tlast,   // frame_last
    // configuration writes
    input  logic                          cfg_we,
    input  logic [sem_pkg::IDX_W-1:0]     cfg_index,
    input  logic [sem_pkg::DIM_W-1:0]     cfg_wdata
);

    localparam int unsigned PW = sem_pkg::PIX_W;
    localparam int unsigned QW = sem_pkg::POS_W;

    // ---- configuration: stored as clamped last column / last row
    logic [QW-1:0] wlast_reg, hlast_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wlast_reg <= sem_pkg::last_index(sem_pkg::WIDTH_RESET);
            hlast_reg <= sem_pkg::last_index(sem_pkg::HEIGHT_RESET);
        end else if (cfg_we) begin
            unique case (cfg_index)
                sem_pkg::CFG_IDX_WIDTH:  wlast_reg <= sem_pkg::last_index(cfg_wdata);
                sem_pkg::CFG_IDX_HEIGHT: hlast_reg <= sem_pkg::last_index(cfg_wdata);
                default: ;
            endcase
        end
    end

    // ---- handshake
    logic accept;
    logic s1_valid_reg, s1_valid_next;
    logic s1_emit, s1_go;
    logic m_valid_reg, m_valid_next;

    assign s1_go    = !s1_emit || !m_valid_reg || m_tready;
    assign s_tready = !s1_valid_reg || s1_go;
    assign accept   = s_tvalid && s_tready;

    // ---- stage 0: position of the incoming pixel
    logic [QW-1:0] col_reg, col_next, row_reg, row_next;
    logic [QW-1:0] col_cur, row_cur;

    always_comb begin
        col_cur  = s_tuser ? '0 : col_reg;
        row_cur  = s_tuser ? '0 : row_reg;
        col_next = col_reg;
        row_next = row_reg;
        if (accept) begin
            if (col_cur >= wlast_reg) begin
                col_next = '0;
                row_next = (row_cur >= hlast_reg) ? '0 : row_cur + 1'b1;
            end else begin
                col_next = col_cur + 1'b1;
                row_next = row_cur;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // ---- stage 1 registers (payload holds while stalled)
    logic [PW-1:0]        s1_px_reg;
    logic [QW-1:0]        s1_col_reg, s1_row_reg;
    logic                 s1_fwd_reg;
    sem_pkg::line_entry_t s1_fwd_data_reg;
    sem_pkg::line_entry_t rd_data, s1_entry, wb_entry;
    logic                 fwd_hit;

    // stage 1 entry: RAM data, or the write-back of the previous beat
    assign s1_entry        = s1_fwd_reg ? s1_fwd_data_reg : rd_data;
    assign wb_entry.upper  = s1_entry.middle;
    assign wb_entry.middle = s1_px_reg;
    assign fwd_hit         = s1_valid_reg && (col_cur == s1_col_reg);

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (accept) begin
            s1_valid_next = 1'b1;
        end else if (s1_go) begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_px_reg       <= s_tdata;
            s1_col_reg      <= col_cur;
            s1_row_reg      <= row_cur;
            s1_fwd_reg      <= fwd_hit;
            s1_fwd_data_reg <= wb_entry;
        end
    end

    sem_line_store u_line_store (
        .aclk    (aclk),
        .rd_en   (accept),
        .rd_addr (col_cur),
        .rd_data (rd_data),
        .wr_en   (s1_valid_reg && s1_go),
        .wr_addr (s1_col_reg),
        .wr_data (wb_entry)
    );

    // ---- window and Sobel arithmetic
    sem_pkg::column_t col_in;
    logic [PW-1:0]    magnitude;

    assign col_in.top = s1_entry.upper;
    assign col_in.mid = s1_entry.middle;
    assign col_in.bot = s1_px_reg;

    sem_kernel u_kernel (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .shift_en  (s1_valid_reg && s1_go),
        .col_in    (col_in),
        .magnitude (magnitude)
    );

    // interior window: centre lies one column and one row back
    assign s1_emit = s1_valid_reg && (s1_col_reg >= 8'd2) && (s1_row_reg >= 8'd2);

    // ---- output register
    logic [23:0] m_data_reg;
    logic        m_last_reg;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (s1_emit && s1_go) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_emit && s1_go) begin
            m_data_reg <= {s1_row_reg - 1'b1, s1_col_reg - 1'b1, magnitude};
            m_last_reg <= (s1_col_reg == wlast_reg) && (s1_row_reg == hlast_reg);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    // ---- assertions
    a_ready_only_blocked_by_stage1 : assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> s1_valid_reg && s1_emit && m_valid_reg)
        else $error("input stalled without a held result");

    a_emit_reaches_output : assert property (@(posedge aclk) disable iff (!aresetn)
        s1_emit && s1_go |=> m_valid_reg)
        else $error("interior result lost before the output register");

    a_forward_needs_writer : assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && s1_fwd_reg |-> $past(s1_valid_reg))
        else $error("forward taken without a write-back in flight");

    a_result_not_border : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_data_reg[15:8] != 8'd0) && (m_data_reg[23:16] != 8'd0))
        else $error("result carries a border coordinate");

endmodule

// ===== rtl/sem_line_store.sv =====
// Two-row line store: one synchronous RAM, one write and one registered read port.
module sem_line_store (
    input  logic                         aclk,
    input  logic                         rd_en,
    input  logic [sem_pkg::ADDR_W-1:0]   rd_addr,
    output sem_pkg::line_entry_t         rd_data,
    input  logic                         wr_en,
    input  logic [sem_pkg::ADDR_W-1:0]   wr_addr,
    input  sem_pkg::line_entry_t         wr_data
);

    sem_pkg::line_entry_t mem [sem_pkg::MAX_WIDTH];
    sem_pkg::line_entry_t rd_data_reg;

    // read-before-write on a shared address; the caller forwards
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/sem_kernel.sv =====
// 3x3 window columns and the Sobel gradient magnitude of the current window.
module sem_kernel (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        shift_en,
    input  sem_pkg::column_t            col_in,
    output logic [sem_pkg::PIX_W-1:0]   magnitude
);

    sem_pkg::column_t old_reg, old_next;   // column x-1 of the centre
    sem_pkg::column_t ctr_reg, ctr_next;   // centre column

    logic [9:0] px_sum, nx_sum, py_sum, ny_sum;
    logic [9:0] dx, dy;
    logic [8:0] sum;

    always_comb begin
        old_next = old_reg;
        ctr_next = ctr_reg;
        if (shift_en) begin
            old_next = ctr_reg;
            ctr_next = col_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            old_reg <= '0;
            ctr_reg <= '0;
        end else begin
            old_reg <= old_next;
            ctr_reg <= ctr_next;
        end
    end

    // Both sides are weighted sums of pixels, so |g| is a plain difference.
    always_comb begin
        px_sum = 10'(col_in.top) + {1'b0, col_in.mid, 1'b0} + 10'(col_in.bot);
        nx_sum = 10'(old_reg.top) + {1'b0, old_reg.mid, 1'b0} + 10'(old_reg.bot);
        py_sum = 10'(old_reg.top) + {1'b0, ctr_reg.top, 1'b0} + 10'(col_in.top);
        ny_sum = 10'(old_reg.bot) + {1'b0, ctr_reg.bot, 1'b0} + 10'(col_in.bot);
        dx     = (px_sum >= nx_sum) ? (px_sum - nx_sum) : (nx_sum - px_sum);
        dy     = (py_sum >= ny_sum) ? (py_sum - ny_sum) : (ny_sum - py_sum);
        // |g/4| truncated toward zero equals |g| >> 2
        sum       = {1'b0, dx[9:2]} + {1'b0, dy[9:2]};
        magnitude = sum[8:1];
    end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the streaming 3x3 Sobel edge magnitude block.
module tb_top;
    import sem_pkg::*;

    localparam int HALF_PERIOD  = 6;
    localparam int RESET_CYCLES = 8;
    localparam int HOLD_CYCLES  = 300;   // long receiver hold-off, fills the block
    localparam int IDLE_LIMIT   = 2000;  // cycles without any beat before giving up
    localparam int PIPE_DELAY   = 6;     // settle time after the last result
    localparam int PIXEL_TARGET = 2600;

    // One expected result beat, fields in m_tdata/m_tlast order.
    typedef struct packed {
        logic             last;
        logic [POS_W-1:0] y;
        logic [POS_W-1:0] x;
        logic [PIX_W-1:0] mag;
    } edge_t;

    // Directed stimulus row: pixel, frame start, optional hand-worked result.
    typedef struct {
        logic [PIX_W-1:0] pix;
        logic             fs;
        bit               known;
        edge_t            res;
    } pixel_row_t;

    logic               aclk;
    logic               aresetn;
    logic               s_tvalid;
    logic               s_tready;
    logic [7:0]         s_tdata;
    logic               s_tuser;
    logic               m_tvalid;
    logic               m_tready;
    logic [23:0]        m_tdata;
    logic               m_tlast;
    logic               cfg_we;
    logic [IDX_W-1:0]   cfg_index;
    logic [DIM_W-1:0]   cfg_wdata;

    // Scoreboard and run control.
    edge_t edges_due[$];
    int    errors      = 0;
    int    pixels_sent = 0;
    int    idle_cycles = 0;
    int    hold_left   = 0;
    bit    hold_req    = 1'b0;
    bit    send_calm   = 1'b0;
    bit    recv_calm   = 1'b0;

    // Predictor state: frame geometry, two rows of history, the two window
    // columns left of the current pixel and the raster position.
    logic [DIM_W-1:0] frame_w_reg;
    logic [DIM_W-1:0] frame_h_reg;
    logic [PIX_W-1:0] row_up2 [0:MAX_WIDTH-1];
    logic [PIX_W-1:0] row_up1 [0:MAX_WIDTH-1];
    bit               up2_known [0:MAX_WIDTH-1];
    bit               up1_known [0:MAX_WIDTH-1];
    int               left_col [0:2];
    int               centre_col [0:2];
    int               col_pos;
    int               row_pos;

    // Directed part, width 3 and height 3. Result rows are worked by hand:
    //  - bottom row white, a lone 5 at mid-left: gx = -10/4 truncates to -2,
    //    gy = -255, magnitude 257/2 = 128 (flooring would give 129)
    //  - one stray pixel, then a frame start restarts the counters
    //  - top-right corner white: gx = gy = 765/4 = 191, magnitude 191
    pixel_row_t demo_rows [0:18] = '{
        '{8'd0,   1'b1, 1'b0, '0},
        '{8'd0,   1'b0, 1'b0, '0},
        '{8'd0,   1'b0, 1'b0, '0},
        '{8'd5,   1'b0, 1'b0, '0},
        '{8'd0,   1'b0, 1'b0, '0},
        '{8'd0,   1'b0, 1'b0, '0},
        '{8'd255, 1'b0, 1'b0, '0},
        '{8'd255, 1'b0, 1'b0, '0},
        '{8'd255, 1'b0, 1'b1, '{1'b1, 8'd1, 8'd1, 8'd128}},
        '{8'd0,   1'b0, 1'b0, '0},
        '{8'd0,   1'b1, 1'b0, '0},
        '{8'd255, 1'b0, 1'b0, '0},
        '{8'd255, 1'b0, 1'b0, '0},
        '{8'd0,   1'b0, 1'b0, '0},
        '{8'd0,   1'b0, 1'b0, '0},
        '{8'd255, 1'b0, 1'b0, '0},
        '{8'd0,   1'b0, 1'b0, '0},
        '{8'd0,   1'b0, 1'b0, '0},
        '{8'd0,   1'b0, 1'b1, '{1'b1, 8'd1, 8'd1, 8'd191}}
    };

    sobel_edge_magnitude_3x3_top u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial aclk = 1'b0;
    always #HALF_PERIOD aclk = ~aclk;

    // Effective frame dimension after clamping to 3..256.
    function automatic int clamp_dim(input logic [DIM_W-1:0] v);
        if (v < DIM_MIN) return int'(DIM_MIN);
        if (v > DIM_MAX) return int'(DIM_MAX);
        return int'(v);
    endfunction

    // Mostly back-to-back, sometimes a short gap, rarely a long one; none when calm or held off.
    function automatic int pick_gap(input bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || hold_left > 0) return 0;
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Image texture: noise, black/white (steep edges) or a flat mid grey.
    function automatic logic [PIX_W-1:0] pick_pixel(input int style);
        case (style)
            1: return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
            2: return 8'(120 + $urandom_range(0, 15));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Advance the predictor by one pixel; produced is set for interior centres.
    task automatic compute_edge(input logic [PIX_W-1:0] pix, input logic fs,
                                output bit produced, output edge_t res);
        int w, h, c, r;
        int a00, a01, a02, a10, a12, a20, a21, a22, gx, gy;
        w = clamp_dim(frame_w_reg);
        h = clamp_dim(frame_h_reg);
        if (fs) begin
            col_pos = 0;
            row_pos = 0;
        end
        c   = col_pos;
        r   = row_pos;
        a02 = int'(row_up2[c]);
        a12 = int'(row_up1[c]);
        a22 = int'(pix);
        produced = (c >= 2) && (r >= 2);
        res = '0;
        if (produced) begin
            a00 = left_col[0];
            a10 = left_col[1];
            a20 = left_col[2];
            a01 = centre_col[0];
            a21 = centre_col[2];
            // SV integer division truncates toward zero, as required
            gx = (a02 - a00 + 2 * (a12 - a10) + a22 - a20) / 4;
            gy = (a00 + 2 * a01 + a02 - a20 - 2 * a21 - a22) / 4;
            if (gx < 0) gx = -gx;
            if (gy < 0) gy = -gy;
            res.mag  = 8'((gx + gy) / 2);
            res.x    = 8'(c - 1);
            res.y    = 8'(r - 1);
            res.last = (c == w - 1) && (r == h - 1);
        end
        left_col      = centre_col;
        centre_col[0] = a02 & 8'hFF;
        centre_col[1] = a12 & 8'hFF;
        centre_col[2] = a22;
        // an upper entry is only meaningful once its middle source was
        up2_known[c] = up1_known[c];
        up1_known[c] = 1'b1;
        row_up2[c]   = row_up1[c];
        row_up1[c]   = pix;
        if (c >= w - 1) begin
            col_pos = 0;
            row_pos = (r >= h - 1) ? 0 : r + 1;
        end else begin
            col_pos = c + 1;
        end
    endtask

    // Offer one pixel beat; predict at the accepting edge.
    task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic fs,
                              input bit known, input edge_t typed);
        int    gap;
        bit    produced;
        edge_t res;
        gap = pick_gap(send_calm);
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        s_tuser  <= fs;
        do @(posedge aclk); while (!s_tready);
        compute_edge(pix, fs, produced, res);
        if (produced) edges_due.push_back(known ? typed : res);
        pixels_sent++;
    endtask

    // Stop offering, wait for every expected beat, then let the pipe settle
    // (border pixels leave nothing in the scoreboard to wait on).
    task automatic drain_pipeline();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (edges_due.size() != 0) @(posedge aclk);
        repeat (PIPE_DELAY) @(posedge aclk);
    endtask

    // Register writes, only called with the block idle.
    task automatic set_frame_size(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                                  input bit write_w, input bit write_h);
        if (write_w) begin
            @(negedge aclk);
            cfg_we      <= 1'b1;
            cfg_index   <= CFG_IDX_WIDTH;
            cfg_wdata   <= w;
            frame_w_reg  = w;
        end
        if (write_h) begin
            @(negedge aclk);
            cfg_we      <= 1'b1;
            cfg_index   <= CFG_IDX_HEIGHT;
            cfg_wdata   <= h;
            frame_h_reg  = h;
        end
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic check_field(input string what, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %h, got %h", $time, what, want, got);
            errors++;
        end
    endtask

    // Result side: compare every accepted beat with the oldest expectation.
    always @(posedge aclk) begin : result_check
        edge_t want;
        if (aresetn === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1) begin
            if (edges_due.size() == 0) begin
                $display("%0t: unexpected result beat: expected none, got data %h last %b",
                         $time, m_tdata, m_tlast);
                errors++;
            end else begin
                want = edges_due.pop_front();
                check_field("edge_magnitude", want.mag, m_tdata[7:0]);
                check_field("out_x", want.x, m_tdata[15:8]);
                check_field("out_y", want.y, m_tdata[23:16]);
                check_field("frame_last", {7'd0, want.last}, {7'd0, m_tlast});
            end
        end
    end

    // Watchdog: any beat on either channel counts as progress.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Receiver: random stalls, calm stretches, and on request one long
    // hold-off so the block backs up and drops s_tready.
    initial begin : receiver
        int stall_left;
        stall_left = 0;
        m_tready   = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES - 1;
                m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                stall_left = pick_gap(recv_calm);
                m_tready  <= (stall_left == 0);
                if (stall_left > 0) stall_left--;
            end
        end
    end

    initial begin : stimulus
        edge_t            none;
        logic [DIM_W-1:0] w_val;
        logic [DIM_W-1:0] h_val;
        bit               wr_w;
        bit               wr_h;
        bit               resume;
        bit               big;
        logic             fs;
        int               w_eff;
        int               h_eff;
        int               style;
        int               frames;
        int               n;

        none      = '0;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = CFG_IDX_WIDTH;
        cfg_wdata = '0;

        // predictor reset; line stores stay unknown like the RAM
        frame_w_reg = WIDTH_RESET;
        frame_h_reg = HEIGHT_RESET;
        col_pos     = 0;
        row_pos     = 0;
        for (int i = 0; i < 3; i++) begin
            left_col[i]   = 0;
            centre_col[i] = 0;
        end
        for (int i = 0; i < MAX_WIDTH; i++) begin
            up2_known[i] = 1'b0;
            up1_known[i] = 1'b0;
        end

        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;

        // Reset geometry: two rows at the reset width and a few pixels into
        // the third, so the first results show where row 0 wrapped.
        for (int i = 0; i < 2 * int'(WIDTH_RESET) + 6; i++) begin
            send_pixel(pick_pixel(0), 1'b0, 1'b0, none);
        end
        drain_pipeline();

        // Directed table on the smallest frame.
        set_frame_size(DIM_MIN, DIM_MIN, 1'b1, 1'b1);
        foreach (demo_rows[i]) begin
            send_pixel(demo_rows[i].pix, demo_rows[i].fs, demo_rows[i].known,
                       demo_rows[i].res);
        end

        // Random phases: mostly clean frames on small geometries, with stray
        // frame starts, partial frames and mid-frame size changes mixed in.
        // Phase 1 runs the widest frame (300 clamps to 256), phase 4 the
        // tallest (0 clamps to width 3, 511 to height 256).
        for (int phase = 0; phase < 6 || pixels_sent < PIXEL_TARGET; phase++) begin
            drain_pipeline();
            big  = (phase == 1) || (phase == 4);
            wr_w = 1'b1;
            wr_h = 1'b1;
            case (phase)
                1: begin
                    w_val = 9'd300;
                    h_val = 9'd3;
                end
                4: begin
                    w_val = 9'd0;
                    h_val = 9'd511;
                end
                default: begin
                    w_val = ($urandom_range(0, 7) == 0) ? 9'($urandom_range(0, 2))
                                                        : 9'($urandom_range(3, 16));
                    h_val = ($urandom_range(0, 7) == 0) ? 9'($urandom_range(0, 2))
                                                        : 9'($urandom_range(3, 6));
                    case ($urandom_range(0, 3))
                        0: wr_h = 1'b0;
                        1: wr_w = 1'b0;
                        default: ;
                    endcase
                end
            endcase
            set_frame_size(w_val, h_val, wr_w, wr_h);
            w_eff = clamp_dim(frame_w_reg);
            h_eff = clamp_dim(frame_h_reg);

            send_calm = ($urandom_range(0, 3) == 0);
            recv_calm = ($urandom_range(0, 3) == 0);
            if (phase % 4 == 1) hold_req = 1'b1;

            // Carry on mid-frame under the new size only if every column the
            // new width can touch already holds real data in both rows.
            resume = !big && (phase > 1) && ($urandom_range(0, 2) == 0);
            for (int c = 0; c < w_eff; c++) begin
                if (!up2_known[c] || !up1_known[c]) resume = 1'b0;
            end

            style  = $urandom_range(0, 3);
            frames = big ? 1 : $urandom_range(1, 3);
            n      = frames * w_eff * h_eff;
            if (!big && $urandom_range(0, 3) == 0) n += $urandom_range(1, w_eff * h_eff - 1);
            for (int i = 0; i < n; i++) begin
                fs = (i == 0 && !resume) || (!big && $urandom_range(0, 79) == 0);
                send_pixel(pick_pixel(style), fs, 1'b0, none);
            end
        end

        drain_pipeline();
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/sem_pkg.sv
rtl/sem_line_store.sv
rtl/sem_kernel.sv
rtl/sobel_edge_magnitude_3x3_top.sv
bench/tb_top.sv
